// ===== src/boundary_tag_first_fit_allocator_core_macros.svh =====
// Assertion macros for the boundary tag allocator checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BTFF_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("boundary tag allocator check failed");

// Consequent checked in the cycle after the antecedent.
`define BTFF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("boundary tag allocator check failed");

`endif

// ===== src/btff_pkg.sv =====
// Shared types, sizes and codes of the boundary tag first-fit allocator.
// No dependencies.
package btff_pkg;

  localparam int HEAP_WORDS = 2048;
  localparam int AW = $clog2(HEAP_WORDS);
  localparam int TW = AW + 1;
  localparam int SW = TW + 1;
  localparam int IW = AW + 2;
  localparam int BW = AW + 3;
  localparam int XW = AW + 5;

  localparam logic [TW-1:0] TAG_INIT = TW'(-(HEAP_WORDS - 2));
  localparam logic [BW-1:0] FREE_INIT = BW'((HEAP_WORDS - 2) * 4);

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [5:0] OP_NOP       = 6'd0;
  localparam logic [5:0] OP_CLR       = 6'd1;
  localparam logic [5:0] OP_LOAD      = 6'd2;
  localparam logic [5:0] OP_RD_I      = 6'd3;
  localparam logic [5:0] OP_STEP      = 6'd4;
  localparam logic [5:0] OP_RD_T      = 6'd5;
  localparam logic [5:0] OP_CAP_S     = 6'd6;
  localparam logic [5:0] OP_FW1       = 6'd7;
  localparam logic [5:0] OP_FW2       = 6'd8;
  localparam logic [5:0] OP_RD_P      = 6'd9;
  localparam logic [5:0] OP_CAP_P     = 6'd10;
  localparam logic [5:0] OP_PW1       = 6'd11;
  localparam logic [5:0] OP_PW2       = 6'd12;
  localparam logic [5:0] OP_PW3       = 6'd13;
  localparam logic [5:0] OP_PW4       = 6'd14;
  localparam logic [5:0] OP_RD_N      = 6'd15;
  localparam logic [5:0] OP_CAP_N     = 6'd16;
  localparam logic [5:0] OP_NW1       = 6'd17;
  localparam logic [5:0] OP_NW2       = 6'd18;
  localparam logic [5:0] OP_NW3       = 6'd19;
  localparam logic [5:0] OP_NW4       = 6'd20;
  localparam logic [5:0] OP_I_CLR     = 6'd21;
  localparam logic [5:0] OP_TAKE      = 6'd22;
  localparam logic [5:0] OP_AL_SET    = 6'd23;
  localparam logic [5:0] OP_AW1       = 6'd24;
  localparam logic [5:0] OP_AW2       = 6'd25;
  localparam logic [5:0] OP_AW3       = 6'd26;
  localparam logic [5:0] OP_AW4       = 6'd27;
  localparam logic [5:0] OP_FIN       = 6'd28;
  localparam logic [5:0] OP_FIN_SAME  = 6'd29;
  localparam logic [5:0] OP_FIN_GRANT = 6'd30;
  localparam logic [5:0] OP_OUT       = 6'd31;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] byte_count;
    logic        block_present;
    logic [10:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] result_index;
    logic [12:0] free_bytes;
    logic [12:0] used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [5:0] op;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_zero;
    logic bytes_zero;
    logic i_ge_t;
    logic i_eq_t;
    logic i_end;
    logic v_zero;
    logic fit;
    logic s_pos;
    logic s_eq_w;
    logic t_pos;
    logic p_ok;
    logic nrd_ok;
    logic n_ok;
    logic room;
    logic split;
    logic out_busy;
  } flags_t;

endpackage

// ===== src/boundary_tag_first_fit_allocator_core.sv =====
// Top level of the boundary tag first-fit heap allocator.
// Depends on btff_pkg, btff_ctrl and btff_dp.
//
//   Channel   Signals                       Payload
//   request   in_valid / in_stall           req_t: type, bytes, present, index
//   result    out_valid / out_stall         rsp_t: status, index, free, used
//
// After reset the tag memory is cleared one word a cycle, all 2048 words, with no request taken.
// One request at a time; each tag visited on a first-fit or block check walk is read, then checked.
// A request holds in_stall through its tag walk and the tag writes of an allocation
// or of a free with both merges, until its result enters the output register.
// The single-port tag memory sets the pace: one read or one write per cycle.
// A finished result waits in the output register while out_stall is high.
module boundary_tag_first_fit_allocator_core import btff_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  cmd_t   cmd;
  flags_t flg;

  btff_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_present  (in_data.block_present),
    .flg         (flg),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  btff_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .flg       (flg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/btff_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module btff_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/btff_dp.sv =====
// Datapath of the allocator: tag memory, walk pointer, sizes, byte totals, result register.
// Depends on btff_pkg and btff_ram.
module btff_dp import btff_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  req_t   in_data,
  input  cmd_t   cmd,
  input  logic   out_stall,
  output flags_t flg,
  output logic   out_valid,
  output rsp_t   out_data
);

  logic [AW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] w_r, w_nxt;
  logic          bz_r, bz_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] t_r, t_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] n_r, n_nxt;
  logic [SW-1:0] sz_r, sz_nxt;
  logic [SW-1:0] g_r, g_nxt;
  logic [AW-1:0] ph_r, ph_nxt;
  logic          split_r, split_nxt;
  logic [BW-1:0] free_r, free_nxt;
  logic [BW-1:0] used_r, used_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_r, out_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [TW-1:0] ram_wdata, ram_rdata;

  logic [SW-1:0] v13, neg13, mag13;
  logic [SW+1:0] wq;
  logic [SW-1:0] w_in;
  logic [SW-1:0] neg_s, neg_n, rr, neg_r;
  logic [XW-1:0] addr_x;
  logic          take_all;

  btff_ram #(.WIDTH(TW), .DEPTH(HEAP_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    v13   = {ram_rdata[TW-1], ram_rdata};
    neg13 = -v13;
    mag13 = v13[SW-1] ? neg13 : v13;
    wq    = ((SW+2)'(in_data.byte_count) + (SW+2)'(3)) >> 2;
    w_in  = wq[SW-1:0] + SW'(wq[0]);
    neg_s = -s_r;
    neg_n = -n_r;
    rr    = sz_r - g_r - SW'(2);
    neg_r = -rr;
    take_all = XW'(sz_r) <= XW'(w_r) + XW'(2);
  end

  always_comb begin
    flg.clr_last   = clr_r == AW'(HEAP_WORDS - 1);
    flg.idx_zero   = idx_r == '0;
    flg.bytes_zero = bz_r;
    flg.i_ge_t     = i_r >= IW'(t_r);
    flg.i_eq_t     = i_r == IW'(t_r);
    flg.i_end      = XW'(i_r) >= XW'(HEAP_WORDS);
    flg.v_zero     = ram_rdata == '0;
    flg.fit        = v13[SW-1] && (neg13 >= w_r);
    flg.s_pos      = !v13[SW-1] && (v13 != '0);
    flg.s_eq_w     = v13 == w_r;
    flg.t_pos      = t_r != '0;
    flg.p_ok       = v13[SW-1] && (XW'(t_r) >= XW'(neg13) + XW'(2));
    flg.nrd_ok     = XW'(t_r) + XW'(s_r) + XW'(2) < XW'(HEAP_WORDS);
    flg.n_ok       = v13[SW-1] &&
                     (XW'(t_r) + XW'(s_r) + XW'(neg13) + XW'(3) < XW'(HEAP_WORDS));
    flg.room       = XW'(i_r) + XW'(sz_r) + XW'(1) < XW'(HEAP_WORDS);
    flg.split      = split_r;
    flg.out_busy   = out_valid_r && out_stall;
  end

  // Tag memory address, write data and strobes per command.
  always_comb begin
    addr_x    = '0;
    ram_wdata = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (cmd.op)
      OP_CLR: begin
        addr_x    = XW'(clr_r);
        ram_wdata = (clr_r == '0 || clr_r == AW'(HEAP_WORDS - 1)) ? TAG_INIT : '0;
        ram_we    = 1'b1;
      end
      OP_RD_I: begin
        addr_x = XW'(i_r);
        ram_re = 1'b1;
      end
      OP_RD_T: begin
        addr_x = XW'(t_r);
        ram_re = 1'b1;
      end
      OP_FW1: begin
        addr_x    = XW'(t_r);
        ram_wdata = neg_s[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_FW2: begin
        addr_x    = XW'(t_r) + XW'(s_r) + XW'(1);
        ram_wdata = neg_s[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_RD_P: begin
        addr_x = XW'(t_r) - XW'(1);
        ram_re = 1'b1;
      end
      OP_PW1: begin
        addr_x    = XW'(ph_r);
        ram_wdata = neg_n[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_PW2: begin
        addr_x    = XW'(t_r) + XW'(s_r) + XW'(1);
        ram_wdata = neg_n[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_PW3: begin
        addr_x = XW'(t_r) - XW'(1);
        ram_we = 1'b1;
      end
      OP_PW4: begin
        addr_x = XW'(t_r);
        ram_we = 1'b1;
      end
      OP_RD_N: begin
        addr_x = XW'(t_r) + XW'(s_r) + XW'(2);
        ram_re = 1'b1;
      end
      OP_NW1: begin
        addr_x = XW'(t_r) + XW'(s_r) + XW'(1);
        ram_we = 1'b1;
      end
      OP_NW2: begin
        addr_x = XW'(t_r) + XW'(s_r) + XW'(2);
        ram_we = 1'b1;
      end
      OP_NW3: begin
        addr_x    = XW'(t_r);
        ram_wdata = neg_n[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_NW4: begin
        addr_x    = XW'(t_r) + XW'(n_r) + XW'(1);
        ram_wdata = neg_n[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_AW1: begin
        addr_x    = XW'(i_r);
        ram_wdata = g_r[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_AW2: begin
        addr_x    = XW'(i_r) + XW'(g_r) + XW'(1);
        ram_wdata = g_r[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_AW3: begin
        addr_x    = XW'(i_r) + XW'(g_r) + XW'(2);
        ram_wdata = neg_r[TW-1:0];
        ram_we    = 1'b1;
      end
      OP_AW4: begin
        addr_x    = XW'(i_r) + XW'(sz_r) + XW'(1);
        ram_wdata = neg_r[TW-1:0];
        ram_we    = 1'b1;
      end
      default: begin
        addr_x = '0;
      end
    endcase
    ram_addr = addr_x[AW-1:0];
  end

  always_comb begin
    clr_nxt       = clr_r;
    w_nxt         = w_r;
    bz_nxt        = bz_r;
    idx_nxt       = idx_r;
    t_nxt         = t_r;
    i_nxt         = i_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    sz_nxt        = sz_r;
    g_nxt         = g_r;
    ph_nxt        = ph_r;
    split_nxt     = split_r;
    free_nxt      = free_r;
    used_nxt      = used_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (cmd.op)
      OP_CLR: clr_nxt = clr_r + AW'(1);
      OP_LOAD: begin
        w_nxt   = w_in;
        bz_nxt  = in_data.byte_count == '0;
        idx_nxt = in_data.block_index;
        t_nxt   = in_data.block_index - AW'(1);
        i_nxt   = '0;
      end
      OP_STEP: i_nxt = i_r + IW'(mag13) + IW'(2);
      OP_CAP_S: s_nxt = v13;
      OP_FW2: begin
        free_nxt = free_r + BW'({s_r, 2'b00});
        used_nxt = used_r - BW'({s_r, 2'b00});
      end
      OP_CAP_P: begin
        ph_nxt = t_r - neg13[AW-1:0] - AW'(2);
        n_nxt  = neg13 + s_r + SW'(2);
      end
      OP_PW4: begin
        free_nxt = free_r + BW'(8);
        t_nxt    = ph_r;
        s_nxt    = n_r;
      end
      OP_CAP_N: n_nxt = s_r + neg13 + SW'(2);
      OP_NW4: free_nxt = free_r + BW'(8);
      OP_I_CLR: i_nxt = '0;
      OP_TAKE: sz_nxt = neg13;
      OP_AL_SET: begin
        g_nxt     = take_all ? sz_r : w_r;
        split_nxt = !take_all;
      end
      OP_AW2: begin
        free_nxt = free_r - BW'({g_r, 2'b00}) - (split_r ? BW'(8) : BW'(0));
        used_nxt = used_r + BW'({g_r, 2'b00});
      end
      OP_FIN: begin
        st_nxt  = cmd.st;
        res_nxt = '0;
      end
      OP_FIN_SAME: begin
        st_nxt  = ST_OK;
        res_nxt = idx_r;
      end
      OP_FIN_GRANT: begin
        st_nxt  = ST_OK;
        res_nxt = i_r[AW-1:0] + AW'(1);
      end
      OP_OUT: begin
        out_nxt.status       = st_r;
        out_nxt.result_index = res_r;
        out_nxt.free_bytes   = free_r[12:0];
        out_nxt.used_bytes   = used_r[12:0];
        out_valid_nxt        = 1'b1;
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      free_r      <= FREE_INIT;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    bz_r    <= bz_nxt;
    idx_r   <= idx_nxt;
    t_r     <= t_nxt;
    i_r     <= i_nxt;
    s_r     <= s_nxt;
    n_r     <= n_nxt;
    sz_r    <= sz_nxt;
    g_r     <= g_nxt;
    ph_r    <= ph_nxt;
    split_r <= split_nxt;
    st_r    <= st_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/btff_ctrl.sv =====
// Sequencer of the allocator: walks, frees, merges and allocations as datapath commands.
// Depends on btff_pkg.
module btff_ctrl import btff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  input  logic       in_present,
  input  flags_t     flg,
  output logic       in_stall,
  output cmd_t       cmd
);

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_START    = 5'd2;
  localparam logic [4:0] S_HD_RD    = 5'd3;
  localparam logic [4:0] S_HD_CHK   = 5'd4;
  localparam logic [4:0] S_HD_TAG   = 5'd5;
  localparam logic [4:0] S_FW1      = 5'd6;
  localparam logic [4:0] S_FW2      = 5'd7;
  localparam logic [4:0] S_PRD      = 5'd8;
  localparam logic [4:0] S_PCHK     = 5'd9;
  localparam logic [4:0] S_PW1      = 5'd10;
  localparam logic [4:0] S_PW2      = 5'd11;
  localparam logic [4:0] S_PW3      = 5'd12;
  localparam logic [4:0] S_PW4      = 5'd13;
  localparam logic [4:0] S_NRD      = 5'd14;
  localparam logic [4:0] S_NCHK     = 5'd15;
  localparam logic [4:0] S_NW1      = 5'd16;
  localparam logic [4:0] S_NW2      = 5'd17;
  localparam logic [4:0] S_NW3      = 5'd18;
  localparam logic [4:0] S_NW4      = 5'd19;
  localparam logic [4:0] S_FEND     = 5'd20;
  localparam logic [4:0] S_AL_START = 5'd21;
  localparam logic [4:0] S_AL_RD    = 5'd22;
  localparam logic [4:0] S_AL_CHK   = 5'd23;
  localparam logic [4:0] S_AL_FIT   = 5'd24;
  localparam logic [4:0] S_AW1      = 5'd25;
  localparam logic [4:0] S_AW2      = 5'd26;
  localparam logic [4:0] S_AW3      = 5'd27;
  localparam logic [4:0] S_AW4      = 5'd28;
  localparam logic [4:0] S_GRANT    = 5'd29;
  localparam logic [4:0] S_DONE     = 5'd30;

  logic [4:0] state_r, state_nxt;
  logic [1:0] req_r, req_nxt;
  logic       pres_r, pres_nxt;
  logic       resize;

  assign in_stall = state_r != S_IDLE;
  assign resize   = (req_r == REQ_REALLOC) && !flg.bytes_zero;

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    pres_nxt  = pres_r;
    cmd.op    = OP_NOP;
    cmd.st    = ST_OK;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (flg.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          req_nxt   = in_req_type;
          pres_nxt  = in_present;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (req_r)
          REQ_ALLOC: state_nxt = S_AL_START;
          REQ_FREE: begin
            if (!pres_r) begin
              cmd.op    = OP_FIN;
              state_nxt = S_DONE;
            end else if (flg.idx_zero) begin
              cmd.op    = OP_FIN;
              cmd.st    = ST_BAD;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_HD_RD;
            end
          end
          REQ_REALLOC: begin
            if (!pres_r) begin
              state_nxt = S_AL_START;
            end else if (flg.idx_zero) begin
              cmd.op    = OP_FIN;
              cmd.st    = ST_BAD;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_HD_RD;
            end
          end
          default: begin
            cmd.op    = OP_FIN;
            state_nxt = S_DONE;
          end
        endcase
      end
      // Walk the tags from word 0 until the pointer reaches the named block.
      S_HD_RD: begin
        if (!flg.i_ge_t) begin
          cmd.op    = OP_RD_I;
          state_nxt = S_HD_CHK;
        end else if (flg.i_eq_t) begin
          cmd.op    = OP_RD_T;
          state_nxt = S_HD_TAG;
        end else begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_BAD;
          state_nxt = S_DONE;
        end
      end
      S_HD_CHK: begin
        if (flg.v_zero) begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_BAD;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_STEP;
          state_nxt = S_HD_RD;
        end
      end
      S_HD_TAG: begin
        if (!flg.s_pos) begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_BAD;
          state_nxt = S_DONE;
        end else if (resize && flg.s_eq_w) begin
          cmd.op    = OP_FIN_SAME;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_CAP_S;
          state_nxt = S_FW1;
        end
      end
      S_FW1: begin
        cmd.op    = OP_FW1;
        state_nxt = S_FW2;
      end
      S_FW2: begin
        cmd.op    = OP_FW2;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        if (flg.t_pos) begin
          cmd.op    = OP_RD_P;
          state_nxt = S_PCHK;
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_PCHK: begin
        cmd.op    = OP_CAP_P;
        state_nxt = flg.p_ok ? S_PW1 : S_NRD;
      end
      S_PW1: begin
        cmd.op    = OP_PW1;
        state_nxt = S_PW2;
      end
      S_PW2: begin
        cmd.op    = OP_PW2;
        state_nxt = S_PW3;
      end
      S_PW3: begin
        cmd.op    = OP_PW3;
        state_nxt = S_PW4;
      end
      S_PW4: begin
        cmd.op    = OP_PW4;
        state_nxt = S_NRD;
      end
      S_NRD: begin
        if (flg.nrd_ok) begin
          cmd.op    = OP_RD_N;
          state_nxt = S_NCHK;
        end else begin
          state_nxt = S_FEND;
        end
      end
      S_NCHK: begin
        cmd.op    = OP_CAP_N;
        state_nxt = flg.n_ok ? S_NW1 : S_FEND;
      end
      S_NW1: begin
        cmd.op    = OP_NW1;
        state_nxt = S_NW2;
      end
      S_NW2: begin
        cmd.op    = OP_NW2;
        state_nxt = S_NW3;
      end
      S_NW3: begin
        cmd.op    = OP_NW3;
        state_nxt = S_NW4;
      end
      S_NW4: begin
        cmd.op    = OP_NW4;
        state_nxt = S_FEND;
      end
      S_FEND: begin
        if (resize) begin
          state_nxt = S_AL_START;
        end else begin
          cmd.op    = OP_FIN;
          state_nxt = S_DONE;
        end
      end
      S_AL_START: begin
        if (flg.bytes_zero) begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_SIZE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_I_CLR;
          state_nxt = S_AL_RD;
        end
      end
      S_AL_RD: begin
        if (flg.i_end) begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_NOFIT;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_RD_I;
          state_nxt = S_AL_CHK;
        end
      end
      S_AL_CHK: begin
        if (flg.v_zero) begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_NOFIT;
          state_nxt = S_DONE;
        end else if (flg.fit) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_AL_FIT;
        end else begin
          cmd.op    = OP_STEP;
          state_nxt = S_AL_RD;
        end
      end
      S_AL_FIT: begin
        if (!flg.room) begin
          cmd.op    = OP_FIN;
          cmd.st    = ST_NOFIT;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_AL_SET;
          state_nxt = S_AW1;
        end
      end
      S_AW1: begin
        cmd.op    = OP_AW1;
        state_nxt = S_AW2;
      end
      S_AW2: begin
        cmd.op    = OP_AW2;
        state_nxt = flg.split ? S_AW3 : S_GRANT;
      end
      S_AW3: begin
        cmd.op    = OP_AW3;
        state_nxt = S_AW4;
      end
      S_AW4: begin
        cmd.op    = OP_AW4;
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        cmd.op    = OP_FIN_GRANT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!flg.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    pres_r <= pres_nxt;
  end

endmodule

// ===== src/btff_chk.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on btff_pkg and the assertion macro header.
`include "boundary_tag_first_fit_allocator_core_macros.svh"

module btff_chk import btff_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input req_t in_data,
  input logic out_valid,
  input logic out_stall,
  input rsp_t out_data
);

  `BTFF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // A failed request never grants a block.
  `BTFF_ASSERT_NOW(a_fail_no_index, out_valid && out_data.status != ST_OK, out_data.result_index == '0)
  // Free and used payload bytes can never exceed the initial free span.
  `BTFF_ASSERT_NOW(a_bytes_bound, out_valid, BW'(out_data.free_bytes) + BW'(out_data.used_bytes) <= FREE_INIT)
  // Requests are handled one at a time.
  `BTFF_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

endmodule

bind boundary_tag_first_fit_allocator_core btff_chk u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for boundary_tag_first_fit_allocator_core.
// Needs btff_pkg and the allocator RTL. A directed table runs first, then random
// allocate, free and reallocate traffic, checked by the table or a tag predictor.
`timescale 1ns / 100ps

module tb;
  import btff_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    req_t rq;
    bit   known;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  // Predictor state: signed tags, one per heap word, and the byte totals.
  int heap_tag[HEAP_WORDS];
  int free_total;
  int used_total;

  rsp_t pending_rsp[$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  row_t plan[$];

  boundary_tag_first_fit_allocator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int even_words(int bytes);
    int w;
    w = (bytes + 3) / 4;
    return w + (w & 1);
  endfunction

  // True if word t is a block head reached by walking the tags from word 0.
  function automatic bit walk_hits(int t);
    int i;
    i = 0;
    if (t < 0 || t >= HEAP_WORDS) return 1'b0;
    while (i < t) begin
      if (heap_tag[i] == 0) return 1'b0;
      i += mag(heap_tag[i]) + 2;
    end
    return i == t;
  endfunction

  function automatic logic [1:0] carve_block(int bytes, output int granted);
    int w, i, v, sz, r;
    granted = 0;
    i = 0;
    v = 0;
    if (bytes == 0) return ST_SIZE;
    w = even_words(bytes);
    while (i < HEAP_WORDS) begin
      v = heap_tag[i];
      if (v == 0) return ST_NOFIT;
      if (v < 0 && -v >= w) break;
      i += mag(v) + 2;
    end
    if (i >= HEAP_WORDS) return ST_NOFIT;
    sz = -v;
    if (i + sz + 1 >= HEAP_WORDS) return ST_NOFIT;
    if (sz <= w + 2) begin
      // The remainder would be too small to hold a block, so grant it all.
      heap_tag[i] = sz;
      heap_tag[i + sz + 1] = sz;
      free_total -= sz * 4;
      used_total += sz * 4;
    end else begin
      r = sz - w - 2;
      heap_tag[i] = w;
      heap_tag[i + w + 1] = w;
      heap_tag[i + w + 2] = -r;
      heap_tag[i + sz + 1] = -r;
      free_total -= w * 4 + 8;
      used_total += w * 4;
    end
    granted = i + 1;
    return ST_OK;
  endfunction

  function automatic void put_back(int t);
    int s, e, ps, ph, n, ns;
    s = heap_tag[t];
    heap_tag[t] = -s;
    heap_tag[t + s + 1] = -s;
    free_total += s * 4;
    used_total -= s * 4;
    if (t > 0 && heap_tag[t - 1] < 0) begin
      ps = -heap_tag[t - 1];
      ph = t - ps - 2;
      n = ps + s + 2;
      if (ph >= 0) begin
        heap_tag[ph] = -n;
        heap_tag[t + s + 1] = -n;
        heap_tag[t - 1] = 0;
        heap_tag[t] = 0;
        free_total += 8;
        t = ph;
        s = n;
      end
    end
    e = t + s + 1;
    if (e + 1 < HEAP_WORDS && heap_tag[e + 1] < 0) begin
      ns = -heap_tag[e + 1];
      n = s + ns + 2;
      if (t + n + 1 < HEAP_WORDS) begin
        heap_tag[e] = 0;
        heap_tag[e + 1] = 0;
        heap_tag[t] = -n;
        heap_tag[t + n + 1] = -n;
        free_total += 8;
      end
    end
  endfunction

  function automatic bit live_head(int t);
    return walk_hits(t) && heap_tag[t] > 0;
  endfunction

  function automatic rsp_t heap_response(req_t rq);
    rsp_t r;
    int   granted, t;
    logic [1:0] st;
    st = ST_OK;
    granted = 0;
    t = int'(rq.block_index) - 1;
    case (rq.req_type)
      REQ_ALLOC: st = carve_block(rq.byte_count, granted);
      REQ_FREE: begin
        if (rq.block_present) begin
          if (!live_head(t)) st = ST_BAD;
          else put_back(t);
        end
      end
      REQ_REALLOC: begin
        if (!rq.block_present) st = carve_block(rq.byte_count, granted);
        else if (!live_head(t)) st = ST_BAD;
        else if (rq.byte_count == 0) put_back(t);
        else if (heap_tag[t] == even_words(rq.byte_count)) granted = rq.block_index;
        else begin
          put_back(t);
          st = carve_block(rq.byte_count, granted);
        end
      end
      default: ;
    endcase
    r.status = st;
    r.result_index = granted[10:0];
    r.free_bytes = free_total[12:0];
    r.used_bytes = used_total[12:0];
    return r;
  endfunction

  function automatic req_t make_req(logic [1:0] op, int bytes, bit present, int idx);
    req_t rq;
    rq.req_type = op;
    rq.byte_count = bytes[13:0];
    rq.block_present = present;
    rq.block_index = idx[10:0];
    return rq;
  endfunction

  function automatic void add_row(req_t rq, bit known = 0, logic [1:0] st = ST_OK,
                                  int idx = 0, int fb = 0, int ub = 0);
    row_t row;
    row.rq = rq;
    row.known = known;
    row.rsp.status = st;
    row.rsp.result_index = idx[10:0];
    row.rsp.free_bytes = fb[12:0];
    row.rsp.used_bytes = ub[12:0];
    plan.push_back(row);
  endfunction

  // Picks a random allocated block head from the predictor, -1 if none.
  function automatic int pick_live();
    int heads[$];
    int i;
    i = 0;
    while (i < HEAP_WORDS && heap_tag[i] != 0) begin
      if (heap_tag[i] > 0) heads.push_back(i);
      i += mag(heap_tag[i]) + 2;
    end
    if (heads.size() == 0) return -1;
    return heads[$urandom_range(heads.size() - 1)];
  endfunction

  function automatic int rand_bytes();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(1, 200);
    if (pick < 95) return $urandom_range(1, 1500);
    return $urandom_range(1, 8192);
  endfunction

  function automatic req_t random_req();
    int pick, head;
    pick = $urandom_range(99);
    head = pick_live();
    if (pick < 45 || (pick < 90 && head < 0))
      return make_req(REQ_ALLOC, rand_bytes(), $urandom_range(1), $urandom_range(2047));
    if (pick < 75)
      return make_req(REQ_FREE, $urandom_range(8192), 1'b1, head + 1);
    if (pick < 80)
      return make_req(REQ_REALLOC, 0, 1'b1, head + 1);
    if (pick < 84)
      return make_req(REQ_REALLOC, heap_tag[head] * 4 - $urandom_range(7), 1'b1, head + 1);
    if (pick < 90)
      return make_req(REQ_REALLOC, rand_bytes(), 1'b1, head + 1);
    // Malformed or odd traffic: stray indexes, null blocks and the unused code.
    case ($urandom_range(3))
      0: return make_req(REQ_FREE, $urandom_range(8192), 1'b1, $urandom_range(2047));
      1: return make_req(REQ_REALLOC, rand_bytes(), 1'b1, $urandom_range(2047));
      2: return make_req(REQ_REALLOC, rand_bytes(), 1'b0, $urandom_range(2047));
      default: return make_req(2'd3, $urandom_range(8192), $urandom_range(1),
                               $urandom_range(2047));
    endcase
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Sends one request and records its expected result once the transfer happens.
  task automatic send_req(req_t rq, bit known, rsp_t typed);
    rsp_t predicted;
    int   gap;
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = heap_response(rq);
    pending_rsp.push_back(known ? typed : predicted);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver stall pattern: bursts of stalls with stall-free stretches in between.
  initial begin
    int n;
    forever begin
      n = gap_len();
      out_stall <= (n > 0);
      repeat (n > 0 ? n : $urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result transfers", 1, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.result_index != want.result_index)
          report_mismatch("result_index", out_data.result_index, want.result_index);
        if (out_data.free_bytes != want.free_bytes)
          report_mismatch("free_bytes", out_data.free_bytes, want.free_bytes);
        if (out_data.used_bytes != want.used_bytes)
          report_mismatch("used_bytes", out_data.used_bytes, want.used_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rsp_t none;
    none = '0;
    for (int i = 0; i < HEAP_WORDS; i++) heap_tag[i] = 0;
    heap_tag[0] = -(HEAP_WORDS - 2);
    heap_tag[HEAP_WORDS - 1] = -(HEAP_WORDS - 2);
    free_total = (HEAP_WORDS - 2) * 4;
    used_total = 0;

    add_row(make_req(REQ_ALLOC, 0, 1'b0, 0), 1, ST_SIZE, 0, 8184, 0);
    add_row(make_req(REQ_FREE, 8192, 1'b0, 2047), 1, ST_OK, 0, 8184, 0);
    add_row(make_req(2'd3, 8192, 1'b1, 2047), 1, ST_OK, 0, 8184, 0);
    add_row(make_req(REQ_FREE, 0, 1'b1, 1), 1, ST_BAD, 0, 8184, 0);
    add_row(make_req(REQ_ALLOC, 8192, 1'b0, 0), 1, ST_NOFIT, 0, 8184, 0);
    add_row(make_req(REQ_ALLOC, 8184, 1'b1, 1365), 1, ST_OK, 1, 0, 8184);
    add_row(make_req(REQ_ALLOC, 1, 1'b0, 0), 1, ST_NOFIT, 0, 0, 8184);
    add_row(make_req(REQ_REALLOC, 8181, 1'b1, 1), 1, ST_OK, 1, 0, 8184);
    add_row(make_req(REQ_FREE, 0, 1'b1, 1), 1, ST_OK, 0, 8184, 0);
    add_row(make_req(REQ_FREE, 0, 1'b1, 1), 1, ST_BAD, 0, 8184, 0);
    add_row(make_req(REQ_ALLOC, 1, 1'b0, 0));
    add_row(make_req(REQ_ALLOC, 9, 1'b0, 0));
    add_row(make_req(REQ_REALLOC, 100, 1'b0, 682));
    add_row(make_req(REQ_ALLOC, 16, 1'b0, 0));
    add_row(make_req(REQ_FREE, 0, 1'b1, 5));
    add_row(make_req(REQ_FREE, 0, 1'b1, 3));
    add_row(make_req(REQ_FREE, 0, 1'b1, 4));
    add_row(make_req(REQ_REALLOC, 50, 1'b1, 1));
    add_row(make_req(REQ_REALLOC, 7000, 1'b1, 11));
    add_row(make_req(REQ_REALLOC, 0, 1'b1, 1));
    add_row(make_req(REQ_ALLOC, 7, 1'b0, 0));
    add_row(make_req(REQ_REALLOC, 0, 1'b1, 2047));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) send_req(plan[k].rq, plan[k].known, plan[k].rsp);
    for (int n = 0; n < 560; n++) begin
      if (n == 280) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      send_req(random_req(), 0, none);
    end
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
